FILE: rtl/transposition_table_probe_store_top_defines.svh
// Assertion macros for the transposition table probe/store block.
// Used by the top level; the enclosing module must provide clk and rst_n.
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_TOP_DEFINES_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ttps_pkg.sv
// Shared types, constants and helpers for the transposition table block.
// No dependencies; every other .sv file in rtl refers to this package.
`timescale 1ns / 1ps

package ttps_pkg;

  // Table depth must be a power of two: the index is the low key bits.
  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int MAX_DEPTH     = 64;
  localparam int Q_DEPTH       = 2;

  localparam int KEY_W       = 64;
  localparam int MOVE_W      = 32;
  localparam int SCORE_W     = 16;
  localparam int DEPTH_W     = 6;
  localparam int PLY_W       = 6;
  localparam int THR_W       = 15;
  localparam int CNT_W       = 32;
  localparam int EXT_W       = 18;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [1:0] {
    OP_PROBE = 2'd0,
    OP_STORE = 2'd1,
    OP_MOVE  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  localparam logic [1:0] BOUND_UPPER = 2'd0;
  localparam logic [1:0] BOUND_LOWER = 2'd1;
  localparam logic [1:0] BOUND_EXACT = 2'd2;
  localparam logic [1:0] BOUND_NONE  = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_MATE_THR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIN      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOSS     = 2'd2;

  localparam logic [THR_W-1:0]          RST_MATE_THR = 15'd29000;
  localparam logic [THR_W-1:0]          RST_WIN      = 15'd30000;
  localparam logic signed [SCORE_W-1:0] RST_LOSS     = -16'sd30000;

  typedef struct packed {
    op_t                        operation;
    logic [KEY_W-1:0]           hash_key;
    logic [MOVE_W-1:0]          move_word;
    logic signed [SCORE_W-1:0]  score_in;
    logic [1:0]                 bound_kind;
    logic [DEPTH_W-1:0]         search_depth;
    logic signed [SCORE_W-1:0]  alpha;
    logic signed [SCORE_W-1:0]  beta;
    logic [PLY_W-1:0]           ply;
  } in_t;

  typedef struct packed {
    logic                       key_match;
    logic                       score_usable;
    logic [MOVE_W-1:0]          move_out;
    logic signed [SCORE_W-1:0]  score_out;
    logic [CNT_W-1:0]           hit_total;
    logic [CNT_W-1:0]           new_write_total;
    logic [CNT_W-1:0]           overwrite_total;
  } out_t;

  typedef struct packed {
    logic [THR_W-1:0]           mate_thr;
    logic [THR_W-1:0]           win;
    logic signed [SCORE_W-1:0]  loss;
  } cfg_t;

  // Decoded command handed from the front end to the back end.
  typedef struct packed {
    op_t                        op;
    logic [KEY_W-1:0]           key;
    logic [MOVE_W-1:0]          move;
    logic signed [SCORE_W-1:0]  score;
    logic [1:0]                 bound;
    logic [DEPTH_W-1:0]         depth;
    logic signed [SCORE_W-1:0]  alpha;
    logic signed [SCORE_W-1:0]  beta;
    logic [PLY_W-1:0]           ply;
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0]           key;
    logic [MOVE_W-1:0]          move;
    logic signed [SCORE_W-1:0]  score;
    logic [1:0]                 bound;
    logic [DEPTH_W-1:0]         depth;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '{
    key:   '0,
    move:  '0,
    score: '0,
    bound: BOUND_NONE,
    depth: '0
  };

  function automatic logic signed [EXT_W-1:0] sext_score(
    input logic signed [SCORE_W-1:0] v
  );
    return EXT_W'(v);
  endfunction

  function automatic logic signed [EXT_W-1:0] zext_thr(input logic [THR_W-1:0] v);
    return $signed({{(EXT_W-THR_W){1'b0}}, v});
  endfunction

endpackage

FILE: rtl/ttps_front.sv
// Front end: accepts input transactions, clamps store scores, saturates depth.
// Depends on ttps_pkg; feeds decoded commands into ttps_queue.
`timescale 1ns / 1ps

module ttps_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ttps_pkg::in_t    in_data,
  input  ttps_pkg::cfg_t   cfg,
  input  logic             init_busy,
  input  logic             q_full,
  output logic             q_push,
  output ttps_pkg::cmd_t   q_data
);

  logic                                valid_r;
  ttps_pkg::cmd_t                      cmd_r;
  ttps_pkg::cmd_t                      cmd_nxt;
  logic                                accept;
  logic signed [ttps_pkg::EXT_W-1:0]   thr_x;
  logic signed [ttps_pkg::EXT_W-1:0]   s_x;
  logic signed [ttps_pkg::EXT_W-1:0]   clamp_x;
  logic signed [ttps_pkg::SCORE_W-1:0] clamp_sc;

  assign in_stall = init_busy || (valid_r && q_full);
  assign accept   = in_valid && !in_stall;
  assign q_push   = valid_r && !q_full;
  assign q_data   = cmd_r;

  always_comb begin
    thr_x    = ttps_pkg::zext_thr(cfg.mate_thr);
    s_x      = ttps_pkg::sext_score(in_data.score_in);
    clamp_sc = in_data.score_in;
    // Winning mate scores first, then the losing test on what remains.
    if (s_x > thr_x) begin
      clamp_sc = $signed({1'b0, cfg.win});
    end
    clamp_x = ttps_pkg::sext_score(clamp_sc);
    if (clamp_x < -thr_x) begin
      clamp_sc = cfg.loss;
    end

    cmd_nxt.op    = in_data.operation;
    cmd_nxt.key   = in_data.hash_key;
    cmd_nxt.move  = in_data.move_word;
    cmd_nxt.score = clamp_sc;
    cmd_nxt.bound = in_data.bound_kind;
    cmd_nxt.alpha = in_data.alpha;
    cmd_nxt.beta  = in_data.beta;
    cmd_nxt.ply   = in_data.ply;
    if (32'(in_data.search_depth) > ttps_pkg::MAX_DEPTH - 1) begin
      cmd_nxt.depth = ttps_pkg::DEPTH_W'(ttps_pkg::MAX_DEPTH - 1);
    end else begin
      cmd_nxt.depth = in_data.search_depth;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
      cmd_r   <= cmd_nxt;
    end else if (q_push) begin
      valid_r <= 1'b0;
    end
  end

endmodule

FILE: rtl/ttps_queue.sv
// Short FIFO of decoded commands between the front and back ends.
// Depends on ttps_pkg for the command type and depth.
`timescale 1ns / 1ps

module ttps_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ttps_pkg::cmd_t  push_data,
  input  logic            pop,
  output logic            full,
  output logic            valid,
  output ttps_pkg::cmd_t  pop_data
);

  localparam int PTR_W = (ttps_pkg::Q_DEPTH > 1) ? $clog2(ttps_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(ttps_pkg::Q_DEPTH + 1);

  ttps_pkg::cmd_t   slot_r [ttps_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_W'(ttps_pkg::Q_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        slot_r[wr_ptr_r] <= push_data;
        wr_ptr_r <= (wr_ptr_r == PTR_W'(ttps_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(ttps_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/ttps_back.sv
// Back end: table memory, clearing sweep, probe/store evaluation, counters
// and the output register. Depends on ttps_pkg; pulls commands from ttps_queue.
`timescale 1ns / 1ps

module ttps_back (
  input  logic            clk,
  input  logic            rst_n,
  input  ttps_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  ttps_pkg::cmd_t  q_data,
  output logic            q_pop,
  output logic            init_busy,
  output logic            out_valid,
  input  logic            out_stall,
  output ttps_pkg::out_t  out_data
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                              state_r;
  logic                                init_r;
  logic [ttps_pkg::IDX_W-1:0]          clr_idx_r;
  ttps_pkg::cmd_t                      cmd_r;
  logic [ttps_pkg::CNT_W-1:0]          hit_r;
  logic [ttps_pkg::CNT_W-1:0]          new_r;
  logic [ttps_pkg::CNT_W-1:0]          over_r;
  logic                                out_valid_r;
  ttps_pkg::out_t                      out_data_r;

  ttps_pkg::entry_t                    mem [ttps_pkg::TABLE_ENTRIES];
  ttps_pkg::entry_t                    rd_r;

  logic                                out_free;
  logic                                exec_go;
  logic                                mem_re;
  logic                                mem_we;
  logic [ttps_pkg::IDX_W-1:0]          mem_raddr;
  logic [ttps_pkg::IDX_W-1:0]          mem_waddr;
  ttps_pkg::entry_t                    mem_wdata;

  logic                                key_hit;
  logic                                deep;
  logic signed [ttps_pkg::EXT_W-1:0]   thr_x;
  logic signed [ttps_pkg::EXT_W-1:0]   ply_x;
  logic signed [ttps_pkg::EXT_W-1:0]   sc0;
  logic signed [ttps_pkg::EXT_W-1:0]   sc1;
  logic signed [ttps_pkg::EXT_W-1:0]   sc2;
  logic signed [ttps_pkg::EXT_W-1:0]   alpha_x;
  logic signed [ttps_pkg::EXT_W-1:0]   beta_x;
  ttps_pkg::out_t                      res;
  logic [ttps_pkg::CNT_W-1:0]          hit_nxt;
  logic [ttps_pkg::CNT_W-1:0]          new_nxt;
  logic [ttps_pkg::CNT_W-1:0]          over_nxt;

  assign init_busy = init_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign exec_go   = (state_r == S_EXEC) && out_free;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign mem_re    = q_pop;
  assign mem_raddr = q_data.key[ttps_pkg::IDX_W-1:0];

  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = ttps_pkg::ENTRY_EMPTY;
    end else begin
      mem_we    = exec_go && (cmd_r.op == ttps_pkg::OP_STORE);
      mem_waddr = cmd_r.key[ttps_pkg::IDX_W-1:0];
      mem_wdata = '{
        key:   cmd_r.key,
        move:  cmd_r.move,
        score: cmd_r.score,
        bound: cmd_r.bound,
        depth: cmd_r.depth
      };
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= mem[mem_raddr];
    end
  end

  // Evaluation of the command against the entry read when it was popped.
  always_comb begin
    res      = '0;
    hit_nxt  = hit_r;
    new_nxt  = new_r;
    over_nxt = over_r;

    key_hit = (rd_r.key == cmd_r.key);
    deep    = (rd_r.depth >= cmd_r.depth);
    thr_x   = ttps_pkg::zext_thr(cfg.mate_thr);
    ply_x   = $signed({{(ttps_pkg::EXT_W - ttps_pkg::PLY_W){1'b0}}, cmd_r.ply});
    alpha_x = ttps_pkg::sext_score(cmd_r.alpha);
    beta_x  = ttps_pkg::sext_score(cmd_r.beta);

    // Mate correction: both tests in turn, the second on the first's result.
    sc0 = ttps_pkg::sext_score(rd_r.score);
    sc1 = (sc0 > thr_x) ? sc0 - ply_x : sc0;
    sc2 = (sc1 < -thr_x) ? sc1 + ply_x : sc1;

    case (cmd_r.op)
      ttps_pkg::OP_PROBE, ttps_pkg::OP_MOVE: begin
        if (key_hit) begin
          res.key_match = 1'b1;
          res.move_out  = rd_r.move;
          if ((cmd_r.op == ttps_pkg::OP_PROBE) && deep) begin
            hit_nxt       = hit_r + 1'b1;
            res.score_out = sc2[ttps_pkg::SCORE_W-1:0];
            case (rd_r.bound)
              ttps_pkg::BOUND_UPPER: begin
                if (sc2 <= alpha_x) begin
                  res.score_out    = cmd_r.alpha;
                  res.score_usable = 1'b1;
                end
              end
              ttps_pkg::BOUND_LOWER: begin
                if (sc2 >= beta_x) begin
                  res.score_out    = cmd_r.beta;
                  res.score_usable = 1'b1;
                end
              end
              ttps_pkg::BOUND_EXACT: begin
                res.score_usable = 1'b1;
              end
              default: begin
                res.score_usable = 1'b0;
              end
            endcase
          end
        end
      end
      ttps_pkg::OP_STORE: begin
        if (rd_r.key == '0) begin
          new_nxt = new_r + 1'b1;
        end else begin
          over_nxt = over_r + 1'b1;
        end
      end
      ttps_pkg::OP_CLEAR: begin
        new_nxt = '0;
      end
      default: begin
        new_nxt = new_r;
      end
    endcase

    res.hit_total       = hit_nxt;
    res.new_write_total = new_nxt;
    res.overwrite_total = over_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      init_r      <= 1'b1;
      clr_idx_r   <= '0;
      hit_r       <= '0;
      new_r       <= '0;
      over_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A result taken while a new one is loaded leaves valid high.
      if (out_valid_r && !out_stall && !exec_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (clr_idx_r == ttps_pkg::IDX_W'(ttps_pkg::TABLE_ENTRIES - 1)) begin
            clr_idx_r <= '0;
            init_r    <= 1'b0;
            state_r   <= S_IDLE;
          end else begin
            clr_idx_r <= clr_idx_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd_r   <= q_data;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res;
            hit_r       <= hit_nxt;
            new_r       <= new_nxt;
            over_r      <= over_nxt;
            state_r     <= (cmd_r.op == ttps_pkg::OP_CLEAR) ? S_CLEAR : S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/transposition_table_probe_store_top.sv
// Transposition table probe/store block. In the back end a probe or store
// reads the table memory synchronously when it is popped from the queue,
// then evaluates the entry, writes it back on a store and loads the result
// register; the next transaction is not popped until that is done, and the
// evaluation waits while a held result is stalled. A clear transaction
// returns its result first and then sweeps the whole table, one entry per
// cycle, during which later transactions wait in the front end and queue.
// After reset the same sweep runs once to empty the table; in_stall is held
// high to its end; configuration writes are taken as usual. The front end
// registers each accepted transaction and clamps store scores, a two-entry
// queue decouples it from the back end, and the result register lets a new
// transaction enter while a finished result still waits on out_stall.
// Depends on ttps_pkg, ttps_front, ttps_queue, ttps_back and the defines
// header for the assertion macros.
`timescale 1ns / 1ps
`include "transposition_table_probe_store_top_defines.svh"

module transposition_table_probe_store_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ttps_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ttps_pkg::out_t                     out_data,
  input  logic                               cfg_wr_en,
  input  logic [ttps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ttps_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ttps_pkg::cfg_t  cfg_r;
  ttps_pkg::cmd_t  fq_data;
  ttps_pkg::cmd_t  qb_data;
  logic            fq_push;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  logic            init_busy;

  // Configuration registers. The user must write them only while the block is
  // idle; the block does not enforce this. The front and back ends use them directly. Unknown indices are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mate_thr <= ttps_pkg::RST_MATE_THR;
      cfg_r.win      <= ttps_pkg::RST_WIN;
      cfg_r.loss     <= ttps_pkg::RST_LOSS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ttps_pkg::CFG_MATE_THR: cfg_r.mate_thr <= cfg_data[ttps_pkg::THR_W-1:0];
        ttps_pkg::CFG_WIN:      cfg_r.win      <= cfg_data[ttps_pkg::THR_W-1:0];
        ttps_pkg::CFG_LOSS:     cfg_r.loss     <= $signed(cfg_data);
        default:                cfg_r          <= cfg_r;
      endcase
    end
  end

  // Front end: takes input transactions and decodes them into commands.
  ttps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .init_busy (init_busy),
    .q_full    (q_full),
    .q_push    (fq_push),
    .q_data    (fq_data)
  );

  // Command queue between the two halves.
  ttps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_data (fq_data),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .pop_data  (qb_data)
  );

  // Back end: table memory, counters and the result register.
  ttps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (qb_data),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The table must be swept empty before the first transaction is taken.
  `TTPS_ASSERT_NOW(a_stall_after_reset, !$past(rst_n), in_stall, "input taken before initial sweep")

  // Once the initial sweep has finished it never starts again.
  `TTPS_ASSERT_NEXT(a_init_once, !init_busy, !init_busy, "initial sweep restarted")

  // A usable score only ever comes from a matching entry.
  `TTPS_ASSERT_NOW(a_usable_needs_match, out_valid && out_data.score_usable, out_data.key_match, "usable score without key match")

  // A miss carries neither a move nor a score.
  `TTPS_ASSERT_NOW(a_miss_is_blank, out_valid && !out_data.key_match, (out_data.move_out == '0) && (out_data.score_out == '0), "miss result carries data")

endmodule

FILE: tb/sv/transposition_table_probe_store_top_tb.sv
// Self-checking testbench for the transposition table probe/store block.
// Depends on ttps_pkg and transposition_table_probe_store_top; a small table
// mirror class predicts every result, plain tasks drive the block's ports.
`timescale 1ns / 1ps

import ttps_pkg::*;

class table_mirror;
  entry_t                    slots [TABLE_ENTRIES];
  logic [CNT_W-1:0]          hits;
  logic [CNT_W-1:0]          fresh_writes;
  logic [CNT_W-1:0]          overwrites;
  logic [THR_W-1:0]          mate_thr;
  logic [THR_W-1:0]          win;
  logic signed [SCORE_W-1:0] loss;
  out_t                      pending [$];
  int                        faults;

  function new();
    wipe();
    hits     = '0;
    overwrites = '0;
    mate_thr = RST_MATE_THR;
    win      = RST_WIN;
    loss     = RST_LOSS;
    faults   = 0;
  endfunction

  function void wipe();
    foreach (slots[i]) slots[i] = ENTRY_EMPTY;
    fresh_writes = '0;
  endfunction

  function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_MATE_THR: mate_thr = data[THR_W-1:0];
      CFG_WIN:      win = data[THR_W-1:0];
      CFG_LOSS:     loss = data;
      default: ;
    endcase
  endfunction

  // Works out the reply to one accepted request and updates the table copy.
  function void take_request(in_t t);
    out_t             r;
    entry_t           e;
    logic [IDX_W-1:0] at;
    int               thr;
    int               sc;
    r   = '0;
    at  = t.hash_key[IDX_W-1:0];
    e   = slots[at];
    thr = int'(mate_thr);
    case (t.operation)
      OP_PROBE, OP_MOVE: begin
        if (e.key == t.hash_key) begin
          r.key_match = 1'b1;
          r.move_out  = e.move;
          if (t.operation == OP_PROBE && e.depth >= t.search_depth) begin
            hits++;
            sc = int'($signed(e.score));
            // Mate scores are pulled towards zero by the distance from root.
            if (sc > thr) sc = sc - int'(t.ply);
            if (sc < -thr) sc = sc + int'(t.ply);
            case (e.bound)
              BOUND_UPPER: begin
                if (sc <= int'($signed(t.alpha))) begin
                  sc = int'($signed(t.alpha));
                  r.score_usable = 1'b1;
                end
              end
              BOUND_LOWER: begin
                if (sc >= int'($signed(t.beta))) begin
                  sc = int'($signed(t.beta));
                  r.score_usable = 1'b1;
                end
              end
              BOUND_EXACT: r.score_usable = 1'b1;
              default: ;
            endcase
            r.score_out = SCORE_W'(sc);
          end
        end
      end
      OP_STORE: begin
        if (e.key == '0) fresh_writes++;
        else overwrites++;
        sc = int'($signed(t.score_in));
        if (sc > thr) sc = int'(win);
        if (sc < -thr) sc = int'($signed(loss));
        slots[at] = '{key: t.hash_key, move: t.move_word, score: SCORE_W'(sc),
                      bound: t.bound_kind, depth: t.search_depth};
      end
      default: wipe();
    endcase
    r.hit_total       = hits;
    r.new_write_total = fresh_writes;
    r.overwrite_total = overwrites;
    pending.push_back(r);
  endfunction

  function void judge(string field, logic signed [63:0] want_v, logic signed [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      faults++;
    end
  endfunction

  function void compare_reply(out_t got);
    out_t want;
    if (pending.size() == 0) begin
      $error("result transaction arrived with nothing outstanding");
      faults++;
      return;
    end
    want = pending.pop_front();
    judge("key_match", want.key_match, got.key_match);
    judge("score_usable", want.score_usable, got.score_usable);
    judge("move_out", want.move_out, got.move_out);
    judge("score_out", want.score_out, got.score_out);
    judge("hit_total", want.hit_total, got.hit_total);
    judge("new_write_total", want.new_write_total, got.new_write_total);
    judge("overwrite_total", want.overwrite_total, got.overwrite_total);
  endfunction
endclass

module transposition_table_probe_store_top_tb;

  // A clear sweeps the whole table before the back end takes anything else,
  // and the receiver has a long hold-off, so the watchdog's QUIET_LIMIT is set
  // above both before it gives up.
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int POOL_SIZE   = 24;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_t                    in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_t                   out_data;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  table_mirror mirror = new();

  // Keys that random requests mostly draw from, so that probes find what
  // earlier stores left behind. The upper half of the pool shares its table
  // index with the lower half, which gives key mismatches and overwrites.
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  transposition_table_probe_store_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Receiver. It stalls at random with the current percentage, and when the
  // stimulus asks for it, it holds off for a long stretch counted here, so
  // that the block's queue fills and it has to stall its own input.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result monitor. Signals are read at the edge before any update of this
  // time step lands, so what is seen is what the block saw.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) mirror.compare_reply(out_data);
  end

  // Watchdog: a run of cycles with no transaction on either channel means the
  // block has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic in_t request(op_t op, logic [KEY_W-1:0] key, logic [MOVE_W-1:0] mv,
                                  int score, logic [1:0] bnd, int depth, int lo, int hi,
                                  int p);
    in_t t;
    t.operation    = op;
    t.hash_key     = key;
    t.move_word    = mv;
    t.score_in     = SCORE_W'(score);
    t.bound_kind   = bnd;
    t.search_depth = DEPTH_W'(depth);
    t.alpha        = SCORE_W'(lo);
    t.beta         = SCORE_W'(hi);
    t.ply          = PLY_W'(p);
    return t;
  endfunction

  // Scores are drawn from the whole range, from near zero, and from close
  // around the mate threshold on either side, where clamping and correction
  // change their behaviour.
  function automatic logic signed [SCORE_W-1:0] pick_score(int thr);
    int v;
    case ($urandom_range(9))
      0, 1, 2: return SCORE_W'($urandom);
      3, 4, 5: return SCORE_W'(int'($urandom_range(400)) - 200);
      default: begin
        v = thr + int'($urandom_range(140)) - 70;
        if (v > 32767) v = 32767;
        if (v < 0) v = 0;
        return SCORE_W'(($urandom_range(1) == 1) ? -v : v);
      end
    endcase
  endfunction

  function automatic in_t random_request();
    in_t t;
    int  pick;
    int  thr;
    thr  = int'(mirror.mate_thr);
    pick = $urandom_range(99);
    // Clears are rare: each one costs a full sweep of the table.
    t.operation = (pick < 45) ? OP_PROBE : (pick < 85) ? OP_STORE :
                  (pick < 98) ? OP_MOVE : OP_CLEAR;
    pick = $urandom_range(99);
    if (pick < 85) t.hash_key = key_pool[$urandom_range(POOL_SIZE - 1)];
    else if (pick < 90) t.hash_key = '0;
    else t.hash_key = {$urandom, $urandom};
    t.move_word    = $urandom;
    t.score_in     = pick_score(thr);
    t.bound_kind   = ($urandom_range(9) == 0) ? BOUND_NONE : 2'($urandom_range(2));
    t.search_depth = DEPTH_W'($urandom_range(63, 1));
    t.alpha        = pick_score(thr);
    t.beta         = pick_score(thr);
    t.ply          = PLY_W'($urandom_range(63));
    return t;
  endfunction

  // Offers one transaction and returns at the edge that accepts it. Valid is
  // left high: the caller either offers the next transaction at once or
  // lowers valid for a gap, so valid gets one assignment per time step.
  task automatic send(input in_t t);
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    mirror.take_request(t);
  endtask

  task automatic idle_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  // The sender stops and waits until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (mirror.pending.size() != 0) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges. Only called while the
  // block has nothing outstanding.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] thr_word,
                              input logic [CFG_DATA_W-1:0] win_word,
                              input logic [CFG_DATA_W-1:0] loss_word);
    logic [CFG_INDEX_W-1:0] idx [3];
    logic [CFG_DATA_W-1:0]  val [3];
    int                     k;
    idx = '{CFG_MATE_THR, CFG_WIN, CFG_LOSS};
    val = '{thr_word, win_word, loss_word};
    for (k = 0; k < 3; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      mirror.set_register(idx[k], val[k]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // One phase of random traffic. When hold_at is reached the receiver is
  // asked for its long hold-off while this side keeps offering back to back.
  task automatic run_phase(input int items, input int gap_pct, input int stall_in,
                           input int hold_at);
    int n;
    stall_pct = stall_in;
    for (n = 0; n < items; n++) begin
      if (n == hold_at) hold_requests++;
      send(random_request());
      if (hold_at < 0 || n < hold_at || n > hold_at + 20) idle_gap(gap_pct);
    end
    drain();
  endtask

  initial begin
    logic [KEY_W-1:0] k1;
    logic [KEY_W-1:0] k2;
    logic [KEY_W-1:0] k3;
    logic [KEY_W-1:0] k4;
    int               i;

    k1 = 64'h0123_4567_89AB_CFFF;   // highest table index
    k2 = 64'hFEDC_BA98_7654_3000;   // index zero, shared with the empty key
    k3 = 64'h0000_0000_0000_0ABC;
    k4 = 64'h5555_AAAA_89AB_CFFF;   // same index as k1, different key

    for (i = 0; i < POOL_SIZE / 2; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = {32'($urandom), 20'($urandom), 12'hFFF};
    key_pool[1] = {32'($urandom), 20'($urandom) | 20'h1, 12'h000};
    key_pool[2] = '1;
    for (i = POOL_SIZE / 2; i < POOL_SIZE; i++) begin
      key_pool[i] = {32'($urandom), 20'($urandom), key_pool[i - POOL_SIZE / 2][11:0]};
    end

    // Reset is held low first; the block then empties its table on its
    // own and keeps its input stalled until that sweep is over.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed transactions with the reset register values.
    // An empty entry holds key zero, so probing key zero matches it.
    send(request(OP_PROBE, '0, '0, 0, BOUND_UPPER, 1, 0, 0, 0));
    send(request(OP_MOVE, '0, '0, 0, BOUND_UPPER, 1, 0, 0, 0));
    send(request(OP_PROBE, k1, '0, 0, BOUND_EXACT, 1, 0, 0, 0));
    // A winning score is clamped on store, then corrected by ply on probe.
    send(request(OP_STORE, k1, '1, 32767, BOUND_EXACT, 63, 0, 0, 0));
    send(request(OP_PROBE, k1, '0, 0, BOUND_UPPER, 63, 32767, -32768, 63));
    // Overwrite with a losing upper bound; a too-shallow probe sees the move
    // only, a deep enough one returns alpha or the corrected score.
    send(request(OP_STORE, k1, '0, -32768, BOUND_UPPER, 10, 0, 0, 0));
    send(request(OP_PROBE, k1, '0, 0, BOUND_UPPER, 11, -100, 0, 5));
    send(request(OP_PROBE, k1, '0, 0, BOUND_UPPER, 10, -100, 0, 5));
    send(request(OP_PROBE, k1, '0, 0, BOUND_UPPER, 1, -32768, 0, 0));
    // A score equal to the threshold is neither clamped nor corrected.
    send(request(OP_STORE, k2, 32'h1, 29000, BOUND_LOWER, 20, 0, 0, 0));
    send(request(OP_PROBE, k2, '0, 0, BOUND_UPPER, 20, 0, 29000, 63));
    send(request(OP_PROBE, k2, '0, 0, BOUND_UPPER, 20, 0, 32767, 63));
    // An entry stored with no bound counts a hit but is never usable.
    send(request(OP_STORE, k3, 32'h55AA, 0, BOUND_NONE, 5, 0, 0, 0));
    send(request(OP_PROBE, k3, '0, 0, BOUND_UPPER, 5, 32767, -32768, 0));
    send(request(OP_MOVE, k2, '0, 0, BOUND_UPPER, 63, 0, 0, 0));
    send(request(OP_PROBE, k4, '0, 0, BOUND_UPPER, 1, 0, 0, 0));
    // Storing key zero over k2 is an overwrite; storing it again over itself
    // looks like an empty entry, so it counts as a new write.
    send(request(OP_STORE, '0, 32'h77, 100, BOUND_EXACT, 1, 0, 0, 0));
    send(request(OP_STORE, '0, 32'h78, 100, BOUND_EXACT, 1, 0, 0, 0));
    // Clear empties the table and only the new-write count.
    send(request(OP_CLEAR, k1, '0, 0, BOUND_UPPER, 1, 0, 0, 0));
    send(request(OP_PROBE, k1, '0, 0, BOUND_UPPER, 1, 0, 0, 0));
    send(request(OP_STORE, k1, 32'hCAFE, -29001, BOUND_EXACT, 7, 0, 0, 0));
    drain();

    // Threshold zero (the top data bit is masked away), a small win value and
    // the most negative loss value: a stored winning score can be corrected
    // down past zero and then back up again.
    program_regs(16'h8000, 16'd5, 16'h8000);
    send(request(OP_STORE, k1, 32'h1234, 1, BOUND_EXACT, 63, 0, 0, 0));
    send(request(OP_PROBE, k1, '0, 0, BOUND_UPPER, 1, 0, 0, 10));
    send(request(OP_STORE, k2, 32'h4321, -1, BOUND_LOWER, 30, 0, 0, 0));
    send(request(OP_PROBE, k2, '0, 0, BOUND_UPPER, 30, 0, -32768, 63));
    send(request(OP_STORE, k3, 32'h9, 0, BOUND_UPPER, 2, 0, 0, 0));
    send(request(OP_PROBE, k3, '0, 0, BOUND_UPPER, 2, 0, 0, 63));
    drain();

    // Random phases, each under its own register setting and idling pattern.
    program_regs(16'd29000, 16'd30000, 16'hFFFF & -16'sd30000);
    run_phase(85, 0, 0, -1);

    program_regs(16'h7FFF, 16'h0000, 16'h0000);
    run_phase(85, 81, 0, -1);

    program_regs(16'h0000, 16'h7FFF, 16'h8000);
    run_phase(85, 0, 81, -1);

    program_regs(16'($urandom), 16'($urandom), {1'b1, 15'($urandom)});
    run_phase(85, 10, 10, -1);

    // No idling, with the receiver's long hold-off part way through.
    program_regs(16'd100, 16'd32000, 16'hFFFF);
    run_phase(85, 0, 0, 20);

    // Everything has come back; give the block a little longer in case it
    // produces something it should not.
    repeat (20) @(posedge clk);
    if (mirror.faults == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
